// ----- rtl/nspf_pkg.sv -----
// ----------------------------------------------------------------------------
// nspf_pkg
// Shared types, constants and tables of the NMEA sentence field parser.
// ----------------------------------------------------------------------------
package nspf_pkg;

  localparam int TERM_BYTES_DEF = 16;
  localparam int PRN_SLOTS      = 12;
  localparam int LL_W           = 26;
  localparam int LLU_W          = 25;
  localparam int HI_W           = 10;
  localparam logic [HI_W-1:0]  HI_CAP     = 10'd1023;
  localparam logic [LLU_W-1:0] LATLON_MAX = 25'd20000000;

  // sentence kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_GGA  = 3'd1;
  localparam logic [2:0] KIND_RMC  = 3'd2;
  localparam logic [2:0] KIND_GLL  = 3'd3;
  localparam logic [2:0] KIND_GSA  = 3'd4;

  // special characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_A      = 8'h41;

  // step strobes from the sequencer to the term unit
  typedef struct packed {
    logic clr;
    logic step;
    logic fin0;
    logic fin1;
    logic fin2;
  } nspf_ctl_t;

  // decoded term values
  typedef struct packed {
    logic [7:0]       first;
    logic [2:0]       hit;
    logic [LLU_W-1:0] latlon;
    logic [6:0]       num99;
    logic [7:0]       num255;
  } nspf_term_t;

  // talker and sentence names, kind k (0..5) and position i (0..4)
  function automatic logic [7:0] kind_char(input logic [2:0] k, input logic [2:0] i);
    logic [39:0] nm;
    unique case (k)
      3'd0:    nm = "GPGGA";
      3'd1:    nm = "GPRMC";
      3'd2:    nm = "GPGLL";
      3'd3:    nm = "GPGSA";
      3'd4:    nm = "GPGSV";
      default: nm = "GPVTG";
    endcase
    unique case (i)
      3'd0:    kind_char = nm[39:32];
      3'd1:    kind_char = nm[31:24];
      3'd2:    kind_char = nm[23:16];
      3'd3:    kind_char = nm[15:8];
      default: kind_char = nm[7:0];
    endcase
  endfunction

endpackage

// ----- rtl/nspf_ram.sv -----
// ----------------------------------------------------------------------------
// nspf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nspf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/nspf_term_unit.sv -----
// ----------------------------------------------------------------------------
// nspf_term_unit
// Walks a term one character a cycle: digit accumulator, fraction weights,
// sentence name match, then a short finish for the lat/lon conversion.
// ----------------------------------------------------------------------------
module nspf_term_unit #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  nspf_pkg::nspf_ctl_t   ctl,
  input  logic [7:0]            ch,
  input  logic [IDX_W-1:0]      idx,
  output nspf_pkg::nspf_term_t  res
);
  import nspf_pkg::*;

  typedef enum logic [2:0] {
    PH_INT  = 3'b001,
    PH_FRAC = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [HI_W-1:0]  hi_r, hi_nxt;
  logic [6:0]       lo_r, lo_nxt;
  logic [13:0]      frac_r, frac_nxt;
  logic [2:0]       fcnt_r, fcnt_nxt;
  logic [5:0]       ok_r, ok_nxt;
  logic [7:0]       first_r;
  logic [19:0]      tenk_r;
  logic [26:0]      deg_r;
  logic [19:0]      q6_r;
  logic [LLU_W-1:0] ll_r;

  logic             is_dig;
  logic [3:0]       dig;
  logic [9:0]       t;
  logic [15:0]      tq;
  logic [3:0]       q;
  logic [13:0]      hi_w;
  logic [9:0]       w;
  logic [41:0]      prod6;
  logic [27:0]      sum;
  logic [8:0]       s255;

  assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig    = 4'(ch - CH_ZERO);
  // last two digits times ten plus the new digit, split by a reciprocal of 100
  assign t      = 10'(lo_r * 10) + 10'(dig);
  assign tq     = 16'(t * 41);
  assign q      = tq[15:12];
  assign hi_w   = 14'(hi_r * 10) + 14'(q);

  // fraction digit weight
  always_comb begin
    unique case (fcnt_r)
      3'd0:    w = 10'd1000;
      3'd1:    w = 10'd100;
      3'd2:    w = 10'd10;
      3'd3:    w = 10'd1;
      default: w = 10'd0;
    endcase
  end

  // one character of the walk
  always_comb begin
    phase_nxt = phase_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    ok_nxt    = ok_r;
    if (ctl.clr) begin
      phase_nxt = PH_INT;
      hi_nxt    = '0;
      lo_nxt    = '0;
      frac_nxt  = '0;
      fcnt_nxt  = '0;
      ok_nxt    = '1;
    end else if (ctl.step) begin
      for (int k = 0; k < 6; k++) begin
        if (idx < IDX_W'(5) && ch != kind_char(3'(k), 3'(idx))) begin
          ok_nxt[k] = 1'b0;
        end
      end
      unique case (phase_r)
        PH_INT: begin
          if (is_dig) begin
            lo_nxt = 7'(t - 10'(q * 100));
            hi_nxt = (hi_w > 14'(HI_CAP)) ? HI_CAP : hi_w[HI_W-1:0];
          end else if (ch == CH_DOT) begin
            phase_nxt = PH_FRAC;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            frac_nxt = frac_r + 14'(dig * w);
            if (fcnt_r < 3'd4) fcnt_nxt = fcnt_r + 3'd1;
          end else begin
            phase_nxt = PH_STOP;
          end
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
    end
  end

  assign prod6 = 42'(tenk_r * 22'd699051);
  assign sum   = 28'(deg_r) + 28'(q6_r);

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    frac_r  <= frac_nxt;
    fcnt_r  <= fcnt_nxt;
    ok_r    <= ok_nxt;
    if (ctl.step && idx == '0) first_r <= ch;
    // finish: minutes scaled, then divided by six, then summed and clamped
    if (ctl.fin0) begin
      tenk_r <= 20'(lo_r * 14'd10000) + 20'(frac_r);
      deg_r  <= 27'(hi_r * 17'd100000);
    end
    if (ctl.fin1) q6_r <= prod6[41:22];
    if (ctl.fin2) ll_r <= (sum > 28'(LATLON_MAX)) ? LATLON_MAX : sum[LLU_W-1:0];
  end

  // small saturated numbers
  assign s255 = 9'(hi_r * 100) + 9'(lo_r);

  always_comb begin
    res.first  = first_r;
    res.latlon = ll_r;
    res.num99  = (hi_r != '0) ? 7'd99 : lo_r;
    res.num255 = (hi_r >= HI_W'(3) || s255 > 9'd255) ? 8'd255 : s255[7:0];
    res.hit    = KIND_NONE;
    for (int k = 5; k >= 0; k--) begin
      if (ok_r[k]) res.hit = 3'(k + 1);
    end
  end

endmodule

// ----- rtl/nmea_sentence_field_parser_core.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_field_parser_core
// NMEA 0183 character parser: sentence kind, position, fix and GSA IDs.
// ----------------------------------------------------------------------------
// One character is taken at a time and gives one result item. A data
// character or '$' goes straight to ST_RESP, and its result is registered
// into the output from there. A ',' , CR, LF or '*' walks the term buffer
// one character a cycle through the shared digit and match unit, then
// passes ST_FIN0, ST_FIN1, ST_FIN2, ST_APPLY and ST_RESP before the next
// character is taken. A result still held by out_stall adds its wait. The
// input is stalled while a character is in work.
module nmea_sentence_field_parser_core #(
  parameter int TERM_BYTES = nspf_pkg::TERM_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_sentence_end,
  output logic [2:0]                       out_sentence_kind,
  output logic signed [nspf_pkg::LL_W-1:0] out_latitude,
  output logic signed [nspf_pkg::LL_W-1:0] out_longitude,
  output logic [7:0]                       out_fix_type,
  output logic                             out_data_good,
  output logic [6:0]                       out_sats_visible,
  output logic                             out_prn_strobe,
  output logic [3:0]                       out_prn_slot,
  output logic [7:0]                       out_prn_id
);
  import nspf_pkg::*;

  localparam int IDX_W = $clog2(TERM_BYTES);
  localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(TERM_BYTES - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WALK  = 7'b0000010,
    ST_FIN0  = 7'b0000100,
    ST_FIN1  = 7'b0001000,
    ST_FIN2  = 7'b0010000,
    ST_APPLY = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       len_r, iss_r, pc_r;
  logic                   dv_r;
  logic [7:0]             fi_r;
  logic [2:0]             kind_r;
  logic signed [LL_W-1:0] lat_r, lon_r;
  logic [7:0]             fix_r;
  logic                   good_r;
  logic [6:0]             sats_r;
  logic                   end_r;
  logic                   str_r;
  logic [3:0]             slot_r;
  logic [7:0]             id_r;

  logic       acc;
  logic       is_comma, is_end, is_dollar;
  logic       we;
  logic [7:0] rdata;
  nspf_ctl_t  ctl;
  nspf_term_t tr;
  logic       has1;
  logic signed [LL_W-1:0] ll_s;
  logic [7:0] base;

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign is_comma  = (in_rx_byte == CH_COMMA);
  assign is_end    = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF) || (in_rx_byte == CH_STAR);
  assign is_dollar = (in_rx_byte == CH_DOLLAR);
  assign we        = acc && !is_comma && !is_end && !is_dollar && (len_r < LEN_MAX);

  // term buffer
  nspf_ram #(.WIDTH(8), .DEPTH(TERM_BYTES)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (len_r),
    .wdata (in_rx_byte),
    .raddr (iss_r),
    .rdata (rdata)
  );

  // sequencer strobes to the term unit
  always_comb begin
    ctl.clr  = acc && (is_comma || is_end);
    ctl.step = (state_r == ST_WALK) && dv_r;
    ctl.fin0 = (state_r == ST_FIN0);
    ctl.fin1 = (state_r == ST_FIN1);
    ctl.fin2 = (state_r == ST_FIN2);
  end

  nspf_term_unit #(.IDX_W(IDX_W)) u_term (
    .clk (clk),
    .ctl (ctl),
    .ch  (rdata),
    .idx (pc_r),
    .res (tr)
  );

  assign has1 = (len_r != '0);
  assign ll_s = $signed({1'b0, tr.latlon});

  // first field number of lat/lon for the current kind
  always_comb begin
    unique case (kind_r)
      KIND_GGA: base = 8'd2;
      KIND_RMC: base = 8'd3;
      KIND_GLL: base = 8'd1;
      default:  base = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      len_r     <= '0;
      iss_r     <= '0;
      pc_r      <= '0;
      dv_r      <= 1'b0;
      fi_r      <= '0;
      kind_r    <= KIND_NONE;
      lat_r     <= '0;
      lon_r     <= '0;
      fix_r     <= '0;
      good_r    <= 1'b0;
      sats_r    <= '0;
      end_r     <= 1'b0;
      str_r     <= 1'b0;
      slot_r    <= '0;
      id_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      // output valid: set when a result is handed over, cleared once taken
      if (state_r == ST_RESP && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            str_r  <= 1'b0;
            slot_r <= '0;
            id_r   <= '0;
            end_r  <= is_end;
            iss_r  <= '0;
            pc_r   <= '0;
            dv_r   <= 1'b0;
            if (is_comma || is_end) begin
              state_r <= ST_WALK;
            end else begin
              state_r <= ST_RESP;
              if (is_dollar) begin
                kind_r <= KIND_NONE;
                fi_r   <= '0;
                len_r  <= '0;
              end else if (len_r < LEN_MAX) begin
                len_r <= len_r + 1'b1;
              end
            end
          end
        end
        // issue a read each cycle, consume the one issued before
        ST_WALK: begin
          dv_r <= (iss_r < len_r);
          if (iss_r < len_r) iss_r <= iss_r + 1'b1;
          if (dv_r) pc_r <= pc_r + 1'b1;
          if (!dv_r && pc_r == len_r) state_r <= ST_FIN0;
        end
        ST_FIN0: state_r <= ST_FIN1;
        ST_FIN1: state_r <= ST_FIN2;
        ST_FIN2: state_r <= ST_APPLY;
        // close the term by sentence kind and field number
        ST_APPLY: begin
          state_r <= ST_RESP;
          if (fi_r == '0) begin
            if (len_r <= IDX_W'(5) && tr.hit != KIND_NONE) kind_r <= tr.hit;
          end else begin
            if (base != '0) begin
              if (fi_r == base) lat_r <= ll_s;
              else if (fi_r == base + 8'd1 && has1 && tr.first == CH_S) lat_r <= -lat_r;
              else if (fi_r == base + 8'd2) lon_r <= ll_s;
              else if (fi_r == base + 8'd3 && has1 && tr.first == CH_W) lon_r <= -lon_r;
            end
            unique case (kind_r)
              KIND_GGA: begin
                if (fi_r == 8'd6) begin
                  good_r <= has1 && (tr.first > CH_ZERO);
                  if (has1 && tr.first == CH_ZERO) fix_r <= '0;
                end else if (fi_r == 8'd7) begin
                  sats_r <= tr.num99;
                end
              end
              KIND_RMC: begin
                if (fi_r == 8'd2) good_r <= has1 && (tr.first == CH_A);
              end
              KIND_GLL: begin
                if (fi_r == 8'd6) good_r <= has1 && (tr.first == CH_A);
              end
              KIND_GSA: begin
                if (fi_r == 8'd2) begin
                  good_r <= has1 && (tr.first > CH_ZERO);
                  fix_r  <= has1 ? tr.first : 8'd0;
                end else if (fi_r >= 8'd3 && fi_r < 8'(3 + PRN_SLOTS)) begin
                  str_r  <= 1'b1;
                  slot_r <= 4'(fi_r - 8'd3);
                  id_r   <= tr.num255;
                end
              end
              default: begin
              end
            endcase
          end
          len_r <= '0;
          if (end_r) fi_r <= '0;
          else if (fi_r != 8'd255) fi_r <= fi_r + 8'd1;
        end
        // hand the result to the output register
        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && (!out_valid || !out_stall)) begin
      out_sentence_end  <= end_r;
      out_sentence_kind <= kind_r;
      out_latitude      <= lat_r;
      out_longitude     <= lon_r;
      out_fix_type      <= fix_r;
      out_data_good     <= good_r;
      out_sats_visible  <= sats_r;
      out_prn_strobe    <= str_r;
      out_prn_slot      <= slot_r;
      out_prn_id        <= id_r;
    end
  end

endmodule

// ----- rtl/nspf_checker.sv -----
// ----------------------------------------------------------------------------
// nspf_checker
// Port level checks of the NMEA sentence field parser, bound to the top level.
// ----------------------------------------------------------------------------
module nspf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_sentence_kind,
  input logic [6:0] out_sats_visible,
  input logic       out_prn_strobe,
  input logic [3:0] out_prn_slot,
  input logic [7:0] out_prn_id
);
  import nspf_pkg::*;

  // an accepted item keeps the input busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item");

  // satellite IDs only come from a GSA sentence and name a real slot
  a_gsa: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prn_strobe |-> out_sentence_kind == KIND_GSA && out_prn_slot < 4'd12)
    else $error("satellite ID outside a GSA sentence");

  // no strobe, no slot and no ID
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_prn_strobe |-> out_prn_slot == '0 && out_prn_id == '0)
    else $error("slot or ID without strobe");

  // satellites in view stay saturated
  a_sats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sats_visible <= 7'd99)
    else $error("satellites in view above 99");

endmodule

bind nmea_sentence_field_parser_core nspf_checker u_nspf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sentence_kind (out_sentence_kind),
  .out_sats_visible  (out_sats_visible),
  .out_prn_strobe    (out_prn_strobe),
  .out_prn_slot      (out_prn_slot),
  .out_prn_id        (out_prn_id)
);
